@@ hw/rtl/websocket_frame_deframer_macros.svh @@
// Assertion macros for the websocket frame deframer.
`ifndef WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH
`define WEBSOCKET_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define WSD_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define WSD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define WSD_ASSERT_NEVER(lbl, clk, rst, cond)
`endif

`endif

@@ hw/rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [6:0] LEN7_MAX_SHORT = 7'd125;
   localparam logic [6:0] LEN7_EXT16     = 7'd126;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_EMPTY = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PH_HDR0   = 3'd0,
      PH_HDR1   = 3'd1,
      PH_EXTLEN = 3'd2,
      PH_MASK   = 3'd3,
      PH_DATA   = 3'd4
   } phase_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [7:0] key;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

@@ hw/rtl/wsd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsd_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [7:0]           req_stream_byte,
   input  wsd_pkg::qstat_type   qstat,
   output logic                 push,
   output wsd_pkg::entry_type   push_entry
);
   import wsd_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [2:0]       count_ff, count_in;
   logic [63:0]      remaining_ff, remaining_in;
   logic [3:0][7:0]  mask_ff, mask_in;
   logic [1:0]       index_ff, index_in;
   logic             fin_ff, fin_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic             rsv_ff, rsv_in;
   logic             ext64_ff, ext64_in;
   logic             closed_ff, closed_in;
   logic             accept;
   logic [6:0]       len7;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;
   assign len7      = req_stream_byte[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         count_ff     <= '0;
         remaining_ff <= '0;
         index_ff     <= '0;
         fin_ff       <= 1'b0;
         opcode_ff    <= '0;
         rsv_ff       <= 1'b0;
         ext64_ff     <= 1'b0;
         closed_ff    <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         index_ff     <= index_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         rsv_ff       <= rsv_in;
         ext64_ff     <= ext64_in;
         closed_ff    <= closed_in;
      end
      mask_ff <= mask_in;
   end

   always_comb begin
      phase_in          = phase_ff;
      count_in          = count_ff;
      remaining_in      = remaining_ff;
      mask_in           = mask_ff;
      index_in          = index_ff;
      fin_in            = fin_ff;
      opcode_in         = opcode_ff;
      rsv_in            = rsv_ff;
      ext64_in          = ext64_ff;
      closed_in         = closed_ff;
      push              = 1'b0;
      push_entry.kind   = KIND_DATA;
      push_entry.data   = '0;
      push_entry.key    = '0;
      push_entry.opcode = opcode_ff;
      push_entry.fin    = fin_ff;
      push_entry.last   = 1'b0;
      if (accept && !closed_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = req_stream_byte[7];
               rsv_in    = |req_stream_byte[6:4];
               opcode_in = req_stream_byte[3:0];
               index_in  = '0;
               count_in  = '0;
               phase_in  = PH_HDR1;
            end
            PH_HDR1: begin
               count_in = '0;
               if (!req_stream_byte[7] || rsv_ff) begin
                  closed_in       = 1'b1;
                  phase_in        = PH_HDR0;
                  push            = 1'b1;
                  push_entry.kind = KIND_ERROR;
               end else if (len7 <= LEN7_MAX_SHORT) begin
                  remaining_in = {57'd0, len7};
                  phase_in     = PH_MASK;
               end else begin
                  ext64_in     = (len7 != LEN7_EXT16);
                  remaining_in = '0;
                  phase_in     = PH_EXTLEN;
               end
            end
            PH_EXTLEN: begin
               remaining_in = {remaining_ff[55:0], req_stream_byte};
               count_in     = count_ff + 3'd1;
               if ((ext64_ff && count_ff == 3'd7) || (!ext64_ff && count_ff == 3'd1)) begin
                  count_in = '0;
                  phase_in = PH_MASK;
               end
            end
            PH_MASK: begin
               mask_in  = {mask_ff[2:0], req_stream_byte};
               count_in = count_ff + 3'd1;
               if (count_ff == 3'd3) begin
                  count_in = '0;
                  index_in = '0;
                  if (remaining_ff == '0) begin
                     phase_in        = PH_HDR0;
                     push            = 1'b1;
                     push_entry.kind = KIND_EMPTY;
                     push_entry.last = 1'b1;
                  end else begin
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               index_in        = index_ff + 2'd1;
               remaining_in    = remaining_ff - 64'd1;
               push            = 1'b1;
               push_entry.data = req_stream_byte;
               push_entry.key  = mask_ff[2'd3 - index_ff];
               push_entry.last = (remaining_ff == 64'd1);
               if (remaining_ff == 64'd1) begin
                  phase_in = PH_HDR0;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/wsd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsd_queue #(
   parameter int DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wsd_pkg::entry_type   push_entry,
   input  wire                  pop,
   output wsd_pkg::entry_type   pop_entry,
   output wsd_pkg::qstat_type   qstat
);
   import wsd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign qstat.full  = (count_ff == CNT_W'(DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_entry   = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

@@ hw/rtl/wsd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module wsd_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wsd_pkg::qstat_type   qstat,
   input  wsd_pkg::entry_type   pop_entry,
   output logic                 pop,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [7:0]           rsp_payload_byte,
   output logic [3:0]           rsp_opcode,
   output logic                 rsp_fin,
   output logic                 rsp_last_of_frame
);
   import wsd_pkg::*;

   logic        valid_ff;
   logic [1:0]  kind_ff;
   logic [7:0]  byte_ff;
   logic [3:0]  opcode_ff;
   logic        fin_ff;
   logic        last_ff;

   assign pop = !qstat.empty && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (pop) begin
         kind_ff   <= pop_entry.kind;
         byte_ff   <= pop_entry.data ^ pop_entry.key;
         opcode_ff <= pop_entry.opcode;
         fin_ff    <= pop_entry.fin;
         last_ff   <= pop_entry.last;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_payload_byte  = byte_ff;
   assign rsp_opcode        = opcode_ff;
   assign rsp_fin           = fin_ff;
   assign rsp_last_of_frame = last_ff;

endmodule
`default_nettype wire

@@ hw/rtl/websocket_frame_deframer.sv @@
// Client-to-server WebSocket frame deframer. One stream byte is accepted per
// cycle while the queue is not full; the header parser's 64-bit length
// counter and mask selection update on each accepted byte. Header bytes
// produce no item; each payload byte produces one unmasked item, a zero-length
// frame one empty-frame item, and a clear mask bit or set RSV bit one error
// item, after which all bytes are taken and dropped until reset. Items pass
// through a QUEUE_DEPTH entry queue and then an output register, and the
// input keeps flowing while the queue has room.
`timescale 1ns / 1ps
`default_nettype none
`include "websocket_frame_deframer_macros.svh"
module websocket_frame_deframer #(
   parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_opcode,
   output logic        rsp_fin,
   output logic        rsp_last_of_frame
);
   import wsd_pkg::*;

   qstat_type  qstat;
   logic       push, pop;
   entry_type  push_entry, pop_entry;

   wsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .qstat           (qstat),
      .push            (push),
      .push_entry      (push_entry)
   );

   wsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   wsd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .qstat             (qstat),
      .pop_entry         (pop_entry),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_opcode        (rsp_opcode),
      .rsp_fin           (rsp_fin),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

   `WSD_ASSERT_NEVER(a_push_full, clock, reset, push && qstat.full)
   `WSD_ASSERT_NEVER(a_pop_empty, clock, reset, pop && qstat.empty)
   `WSD_ASSERT_IMP(a_ctl_zero, clock, reset, rsp_valid && rsp_kind != KIND_DATA, rsp_payload_byte == 8'd0)
   `WSD_ASSERT_IMP(a_err_last, clock, reset, rsp_valid && rsp_kind == KIND_ERROR, !rsp_last_of_frame)

endmodule
`default_nettype wire
